### design/bsd_pkg.sv
// ----------------------------------------------------------------------------
// bsd_pkg
// Shared constants and types of the byte stuffing deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package bsd_pkg;

    localparam logic [7:0] FLAG_BYTE = 8'h7E;
    localparam logic [7:0] ESC_BYTE  = 8'h7D;
    localparam logic [7:0] ESC_XOR   = 8'h20;

    localparam int unsigned INDEX_W  = 7;
    localparam logic [INDEX_W-1:0] INDEX_MAX = '1;

    // One decoded payload byte with its position and end mark.
    typedef struct packed {
        logic [7:0]         data_byte;
        logic [INDEX_W-1:0] byte_index;
        logic               end_of_packet;
    } t_result;

endpackage

`default_nettype wire

### design/bsd_in_stage.sv
// ----------------------------------------------------------------------------
// bsd_in_stage
// Input register that holds one received byte until the decoder takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module bsd_in_stage (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_advance,
    output logic            o_valid,
    output logic [7:0]      o_byte
);

    logic       r_valid;
    logic [7:0] r_byte;

    // The register frees up in the same cycle that its item moves on.
    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_byte  = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_byte <= i_byte;
        end
    end

endmodule

`default_nettype wire

### design/bsd_step.sv
// ----------------------------------------------------------------------------
// bsd_step
// Frame state and the flag, escape and count decision for one byte.
// ----------------------------------------------------------------------------
`default_nettype none

module bsd_step #(
    parameter int unsigned PACKET_BYTES = 32
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_advance,
    input  wire logic [7:0] i_byte,
    output logic            o_emit,
    output bsd_pkg::t_result o_result
);

    localparam logic [bsd_pkg::INDEX_W:0] PKT_LEN = (bsd_pkg::INDEX_W+1)'(PACKET_BYTES);

    logic                        r_in_frame;
    logic                        r_escape;
    logic [bsd_pkg::INDEX_W-1:0] r_count;

    logic                        n_in_frame;
    logic                        n_escape;
    logic [bsd_pkg::INDEX_W-1:0] n_count;
    logic                        last;

    assign last = ({1'b0, r_count} + 1'b1 >= PKT_LEN) || (r_count == bsd_pkg::INDEX_MAX);

    always_comb begin
        n_in_frame = r_in_frame;
        n_escape   = r_escape;
        n_count    = r_count;
        o_emit     = 1'b0;
        o_result.data_byte     = i_byte;
        o_result.byte_index    = r_count;
        o_result.end_of_packet = last;
        // An escaped byte is never checked for a flag.
        priority if (r_escape) begin
            n_escape = 1'b0;
            o_result.data_byte = i_byte ^ bsd_pkg::ESC_XOR;
            o_emit = 1'b1;
        end else if (i_byte == bsd_pkg::FLAG_BYTE) begin
            n_in_frame = 1'b1;
            n_count    = '0;
        end else if (!r_in_frame) begin
            n_in_frame = 1'b0;
        end else if (i_byte == bsd_pkg::ESC_BYTE) begin
            n_escape = 1'b1;
        end else begin
            o_emit = 1'b1;
        end
        if (o_emit) begin
            if (last) begin
                n_in_frame = 1'b0;
                n_count    = '0;
            end else begin
                n_count = r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_escape   <= 1'b0;
            r_count    <= '0;
        end else if (i_advance) begin
            r_in_frame <= n_in_frame;
            r_escape   <= n_escape;
            r_count    <= n_count;
        end
    end

endmodule

`default_nettype wire

### design/bsd_out_reg.sv
// ----------------------------------------------------------------------------
// bsd_out_reg
// Result register that holds one decoded item until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module bsd_out_reg (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  wire bsd_pkg::t_result i_result,
    output logic                  o_space,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output bsd_pkg::t_result      o_result
);

    logic             r_valid;
    bsd_pkg::t_result r_result;

    assign o_space  = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

`default_nettype wire

### design/byte_stuffing_deframer_rx.sv
// ----------------------------------------------------------------------------
// byte_stuffing_deframer_rx
// Receive side deframer for flag and escape byte stuffed packets.
// ----------------------------------------------------------------------------
// The block takes one received byte per item and delivers the unescaped
// payload bytes of each packet, each with its index from zero and an end
// mark on the last byte. A 0x7E flag starts a new frame and yields nothing.
// Inside a frame, 0x7D yields nothing and marks the next byte, which is
// XORed with 0x20 and delivered even if it is a flag. After PACKET_BYTES
// bytes (1 to 128) the packet ends and the block hunts for the next flag;
// bytes outside a frame are dropped. One item is accepted every cycle
// unless a result waits for room in the result register: a byte goes
// through an input register, the combinational flag and escape decision
// and a result register. The result register frees up in the cycle its
// item is taken, so a stalled sink stalls the input only when both
// registers are full.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_stuffing_deframer_rx #(
    parameter int unsigned PACKET_BYTES = 32
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [7:0]      o_data_byte,
    output logic [6:0]      o_byte_index,
    output logic            o_end_of_packet
);

    logic             stage_valid;
    logic [7:0]       stage_byte;
    logic             advance;
    logic             emit;
    logic             out_space;
    bsd_pkg::t_result step_result;
    bsd_pkg::t_result out_result;

    // A byte that yields nothing moves on at once; one that yields a result
    // waits for room in the result register.
    assign advance = stage_valid && (!emit || out_space);

    bsd_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_byte    (i_rx_byte),
        .i_advance (advance),
        .o_valid   (stage_valid),
        .o_byte    (stage_byte)
    );

    bsd_step #(
        .PACKET_BYTES (PACKET_BYTES)
    ) u_step (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_byte    (stage_byte),
        .o_emit    (emit),
        .o_result  (step_result)
    );

    bsd_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance && emit),
        .i_result (step_result),
        .o_space  (out_space),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (out_result)
    );

    assign o_data_byte     = out_result.data_byte;
    assign o_byte_index    = out_result.byte_index;
    assign o_end_of_packet = out_result.end_of_packet;

endmodule

`default_nettype wire

### bench/byte_stuffing_deframer_rx_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// byte_stuffing_deframer_rx_test
// Self-checking bench for the flag and escape byte stuffing receive deframer.
// ----------------------------------------------------------------------------
// A queue of line bytes is built up front: a short directed run, then mostly
// well-formed frames with random payload, escapes and escaped flags, mixed
// with frames cut short by a new flag, repeated flags and noise between
// packets. A clocked driver feeds the queue into the block and a clocked
// monitor compares every delivered payload byte, field by field, against a
// shadow decoder that is updated on every accepted line byte. Both sides of
// the handshake idle in random bursts, except near the end of the run.
// ----------------------------------------------------------------------------

module byte_stuffing_deframer_rx_test;

    localparam int unsigned PKT_LEN      = 32;
    localparam int unsigned ITEM_GOAL    = 1400;
    localparam int unsigned CALM_TAIL    = 150;
    localparam int unsigned DRAIN_CYCLES = 12;
    localparam int unsigned LIMIT_CYCLES = 200000;
    localparam int unsigned MAX_REPORTS  = 10;

    logic       i_clk           = 1'b0;
    logic       i_rst_n         = 1'b0;
    logic       i_valid         = 1'b0;
    logic       o_ready;
    logic [7:0] i_rx_byte       = '0;
    logic       o_valid;
    logic       i_ready         = 1'b0;
    logic [7:0] o_data_byte;
    logic [6:0] o_byte_index;
    logic       o_end_of_packet;

    byte_stuffing_deframer_rx #(
        .PACKET_BYTES(PKT_LEN)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_rx_byte      (i_rx_byte),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_data_byte    (o_data_byte),
        .o_byte_index   (o_byte_index),
        .o_end_of_packet(o_end_of_packet)
    );

    // 10 ns clock, low half first.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Line bytes still to be sent and payload bytes still to be delivered.
    logic [7:0]       line_bytes[$];
    bsd_pkg::t_result predicted_bytes[$];

    // Shadow decoder state.
    logic                        shadow_in_frame   = 1'b0;
    logic                        shadow_esc        = 1'b0;
    logic [bsd_pkg::INDEX_W-1:0] shadow_count      = '0;

    int unsigned cycle_count   = 0;
    logic        in_taken      = 1'b0;
    logic        feed_done     = 1'b0;
    int unsigned src_gap       = 0;
    int unsigned snk_left      = 0;
    int unsigned bytes_sent    = 0;
    int unsigned bytes_checked = 0;
    int unsigned packets_done  = 0;
    int unsigned escapes_seen  = 0;
    int unsigned flags_seen    = 0;
    int unsigned errors        = 0;

    // Runs one accepted line byte through the shadow decoder. An escaped
    // byte is always data, even when it is a flag; a flag otherwise opens a
    // fresh frame, and anything outside a frame is dropped.
    task automatic unstuff_byte(input logic [7:0] rx);
        logic [7:0]                  c;
        logic [bsd_pkg::INDEX_W-1:0] idx;
        logic                        last;
        bsd_pkg::t_result            r;
        c = rx;
        if (shadow_esc) begin
            shadow_esc = 1'b0;
            c = rx ^ bsd_pkg::ESC_XOR;
        end else if (rx == bsd_pkg::FLAG_BYTE) begin
            shadow_in_frame = 1'b1;
            shadow_count = '0;
            flags_seen++;
            return;
        end else if (!shadow_in_frame) begin
            return;
        end else if (rx == bsd_pkg::ESC_BYTE) begin
            shadow_esc = 1'b1;
            escapes_seen++;
            return;
        end
        idx  = shadow_count;
        last = (int'(idx) + 1 >= int'(PKT_LEN)) || (idx == bsd_pkg::INDEX_MAX);
        r.data_byte     = c;
        r.byte_index    = idx;
        r.end_of_packet = last;
        predicted_bytes.push_back(r);
        if (last) begin
            shadow_in_frame = 1'b0;
            shadow_count = '0;
        end else begin
            shadow_count = idx + 1'b1;
        end
    endtask

    // Sampling at the rising edge: input acceptance feeds the shadow
    // decoder, and each delivered byte is checked against the oldest
    // prediction.
    always @(posedge i_clk) begin
        bsd_pkg::t_result want;
        cycle_count <= cycle_count + 1;
        in_taken <= i_rst_n && i_valid && o_ready;
        if (i_rst_n && i_valid && o_ready) begin
            bytes_sent++;
            unstuff_byte(i_rx_byte);
        end
        if (i_rst_n && o_valid && i_ready) begin
            bytes_checked++;
            if (predicted_bytes.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("[%0t] unexpected result: data %02h index %0d eop %0b",
                             $realtime, o_data_byte, o_byte_index, o_end_of_packet);
                end
            end else begin
                want = predicted_bytes.pop_front();
                if (want.end_of_packet) begin
                    packets_done++;
                end
                if (o_data_byte !== want.data_byte ||
                    o_byte_index !== want.byte_index ||
                    o_end_of_packet !== want.end_of_packet) begin
                    errors++;
                    if (errors <= MAX_REPORTS) begin
                        $display("[%0t] mismatch: want %02h/%0d/%0b got %02h/%0d/%0b",
                                 $realtime, want.data_byte, want.byte_index,
                                 want.end_of_packet, o_data_byte, o_byte_index,
                                 o_end_of_packet);
                    end
                end
            end
        end
    end

    // Driving at the falling edge: reset, the source side from the queue of
    // line bytes, and the sink's ready. A source gap only starts between
    // items, never while an item waits for acceptance.
    always @(negedge i_clk) begin
        logic calm;
        calm = (line_bytes.size() < CALM_TAIL);
        i_rst_n <= (cycle_count >= 2);

        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !in_taken) begin
            // The pending item stays on the port unchanged.
        end else if (src_gap > 0) begin
            src_gap--;
            i_valid <= 1'b0;
        end else if (line_bytes.size() == 0) begin
            i_valid <= 1'b0;
            feed_done <= 1'b1;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            src_gap = $urandom_range(0, 15);
            i_valid <= 1'b0;
        end else begin
            i_valid <= 1'b1;
            i_rx_byte <= line_bytes.pop_front();
        end

        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (snk_left > 0) begin
            snk_left--;
        end else if (calm) begin
            i_ready <= 1'b1;
        end else begin
            // Random stretches of ready or stall, about a third of them stalls.
            i_ready <= ($urandom_range(0, 2) != 0);
            snk_left = $urandom_range(0, 15);
        end
    end

    initial begin
        int unsigned counted;
        int unsigned cut;
        int unsigned sel;
        int unsigned n;
        logic [7:0]  b;
        logic        esc;
        logic        timed_out;

        // Directed part. The first bytes arrive before any flag and must be
        // dropped, the escape byte among them.
        line_bytes = '{8'h41, bsd_pkg::ESC_BYTE, 8'h00,
                       bsd_pkg::FLAG_BYTE, bsd_pkg::FLAG_BYTE, 8'h00, 8'hFF,
                       bsd_pkg::ESC_BYTE, bsd_pkg::FLAG_BYTE, // escaped flag is data 0x5E
                       bsd_pkg::ESC_BYTE, bsd_pkg::ESC_BYTE,  // escaped escape is data 0x5D
                       bsd_pkg::ESC_BYTE, 8'h00,
                       bsd_pkg::ESC_BYTE, 8'hFF,
                       8'h55, 8'hAA,
                       bsd_pkg::FLAG_BYTE,                    // restarts the frame at index 0
                       8'h01, 8'h80, 8'h7F, 8'hFE};
        counted = 0;

        // Random part: mostly complete packets with random payload.
        while (counted < ITEM_GOAL) begin
            sel = $urandom_range(0, 9);
            line_bytes.push_back(bsd_pkg::FLAG_BYTE);
            counted++;
            if (sel == 3) begin
                line_bytes.push_back(bsd_pkg::FLAG_BYTE);
                counted++;
            end
            // One frame in ten is cut short by the next flag.
            cut = (sel == 0) ? $urandom_range(0, PKT_LEN - 1) : PKT_LEN;
            for (int k = 0; k < int'(cut); k++) begin
                b = 8'($urandom_range(0, 255));
                esc = (b == bsd_pkg::FLAG_BYTE) || (b == bsd_pkg::ESC_BYTE) ||
                      ($urandom_range(0, 9) == 0);
                if ($urandom_range(0, 31) == 0) begin
                    // Payload 0x5E travels as an escaped flag.
                    b = bsd_pkg::FLAG_BYTE ^ bsd_pkg::ESC_XOR;
                    esc = 1'b1;
                end
                if (esc) begin
                    line_bytes.push_back(bsd_pkg::ESC_BYTE);
                    line_bytes.push_back(b ^ bsd_pkg::ESC_XOR);
                    counted += 2;
                end else begin
                    line_bytes.push_back(b);
                    counted++;
                end
            end
            // Noise between packets, escape bytes included; it is dropped.
            if (sel == 2) begin
                n = $urandom_range(1, 4);
                repeat (n) begin
                    b = 8'($urandom_range(0, 255));
                    line_bytes.push_back((b == bsd_pkg::FLAG_BYTE) ? bsd_pkg::ESC_BYTE : b);
                end
            end
        end

        // Wait for the queue to drain and every prediction to be met.
        while (!(feed_done && predicted_bytes.size() == 0) &&
               cycle_count < LIMIT_CYCLES) begin
            @(negedge i_clk);
        end
        timed_out = (cycle_count >= LIMIT_CYCLES);
        if (!timed_out) begin
            // Give the pipeline time to show any stray result.
            repeat (DRAIN_CYCLES) @(negedge i_clk);
        end

        if (timed_out) begin
            $display("Run stopped at the cycle limit with %0d results outstanding.",
                     predicted_bytes.size());
            $display("** byte_stuffing_deframer_rx: FAILED **");
        end else begin
            if (predicted_bytes.size() != 0) begin
                errors += predicted_bytes.size();
                $display("%0d predicted results never arrived.",
                         predicted_bytes.size());
            end
            $display("Sent %0d line bytes; checked %0d payload bytes in %0d complete packets.",
                     bytes_sent, bytes_checked, packets_done);
            $display("Decoder saw %0d flags and %0d escapes; %0d errors.",
                     flags_seen, escapes_seen, errors);
            if (errors == 0) begin
                $display("** byte_stuffing_deframer_rx: PASSED **");
            end else begin
                $display("** byte_stuffing_deframer_rx: FAILED **");
            end
        end
        $finish;
    end

endmodule
